FILE: design/assert_macros.svh
// Assertion helpers used by the top-level design file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define SDF_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
	else $error(msg);

// Next-cycle implication, checked outside reset.
`define SDF_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
	else $error(msg);

`endif

FILE: design/sdf_pkg.sv
package sdf_pkg;

	localparam int VEC_W  = 32;
	localparam int WIDE_W = 64;

	// Digit-serial square root and long-division step counts.
	localparam int SQRT_STEPS = 32;
	localparam int DIV_STEPS  = 31;

	localparam int NORM_LAT  = 5 + SQRT_STEPS + 1 + DIV_STEPS + 1;
	localparam int CROSS_LAT = 2;
	localparam int TH_LAT    = 2;
	localparam int FRAME_LAT = 3 * NORM_LAT + 2 * CROSS_LAT + TH_LAT + 1;

	// (1e-6 * 2^30)^2 rounded down, in Q4.60.
	localparam logic [WIDE_W-1:0] FB_THRESH_SQ = 64'd1152921;

	localparam logic [VEC_W-1:0] REF_X_RST = 32'd0;
	localparam logic [VEC_W-1:0] REF_Y_RST = 32'd65536;
	localparam logic [VEC_W-1:0] REF_Z_RST = 32'd0;

	typedef logic [2:0][VEC_W-1:0]  vec_t;
	typedef logic [2:0][WIDE_W-1:0] wvec_t;

	typedef enum logic [1:0] {
		REG_REF_X = 2'd0,
		REG_REF_Y = 2'd1,
		REG_REF_Z = 2'd2
	} cfg_reg_t;

	typedef struct packed {
		logic last;
		logic ok;
		logic fb;
		logic ok1;
	} ctl_t;

endpackage

FILE: design/sdf_isqrt.sv
module sdf_isqrt import sdf_pkg::*; #(
	parameter int SIDE_W = 1
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              vld_in,
	input  logic [63:0]       rad_in,
	input  logic [SIDE_W-1:0] side_in,
	output logic              vld_out,
	output logic [31:0]       root_out,
	output logic [SIDE_W-1:0] side_out
);

	localparam int RW = 36;

	logic [RW-1:0]     rem_s  [SQRT_STEPS];
	logic [31:0]       root_s [SQRT_STEPS];
	logic [63:0]       rad_s  [SQRT_STEPS];
	logic [SIDE_W-1:0] side_s [SQRT_STEPS];
	logic              vld_s  [SQRT_STEPS];

	// One root bit per stage, two radicand bits consumed per stage.
	for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_step
		logic [RW-1:0]     rem_i, r2, test;
		logic [31:0]       root_i;
		logic [63:0]       rad_i;
		logic [SIDE_W-1:0] side_i;
		logic              vld_i;

		if (k == 0) begin : g_first
			assign rem_i  = '0;
			assign root_i = '0;
			assign rad_i  = rad_in;
			assign side_i = side_in;
			assign vld_i  = vld_in;
		end else begin : g_next
			assign rem_i  = rem_s[k-1];
			assign root_i = root_s[k-1];
			assign rad_i  = rad_s[k-1];
			assign side_i = side_s[k-1];
			assign vld_i  = vld_s[k-1];
		end

		assign r2   = {rem_i[RW-3:0], rad_i[63-2*k -: 2]};
		assign test = {{(RW-34){1'b0}}, root_i, 2'b01};

		always_ff @(posedge clk) begin
			if (r2 >= test) begin
				rem_s[k]  <= r2 - test;
				root_s[k] <= {root_i[30:0], 1'b1};
			end else begin
				rem_s[k]  <= r2;
				root_s[k] <= {root_i[30:0], 1'b0};
			end
			rad_s[k]  <= rad_i;
			side_s[k] <= side_i;
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k] <= 1'b0;
			end else begin
				vld_s[k] <= vld_i;
			end
		end
	end

	assign vld_out  = vld_s[SQRT_STEPS-1];
	assign root_out = root_s[SQRT_STEPS-1];
	assign side_out = side_s[SQRT_STEPS-1];

endmodule

FILE: design/sdf_norm.sv
module sdf_norm import sdf_pkg::*; #(
	parameter int SIDE_W = 1
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              vld_in,
	input  wvec_t             vec_in,
	input  logic [SIDE_W-1:0] side_in,
	output logic              vld_out,
	output vec_t              vec_out,
	output logic              ok_out,
	output logic [SIDE_W-1:0] side_out
);

	localparam int IS_W = 3 * 31 + 3 + SIDE_W;

	// Right shift that brings every magnitude below 2^31.
	function automatic logic [5:0] red_shift(input logic [63:0] x);
		logic [5:0] s;
		s = '0;
		for (int i = 31; i < 64; i++) begin
			if (x[i]) s = 6'(i - 30);
		end
		return s;
	endfunction

	logic [2:0][63:0]  mag_s1, mag_s2;
	logic [2:0]        neg_s1, neg_s2, neg_s3, neg_s4, neg_s5;
	logic [5:0]        sh_s2;
	logic [2:0][30:0]  m_s3, m_s4, m_s5;
	logic [2:0][61:0]  sq_s4;
	logic [63:0]       sum_s5;
	logic [SIDE_W-1:0] side_s1, side_s2, side_s3, side_s4, side_s5;
	logic              vld_s1, vld_s2, vld_s3, vld_s4, vld_s5;

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			neg_s1[i] <= vec_in[i][63];
			mag_s1[i] <= vec_in[i][63] ? (64'd0 - vec_in[i]) : vec_in[i];
			m_s3[i]   <= 31'(mag_s2[i] >> sh_s2);
			sq_s4[i]  <= m_s3[i] * m_s3[i];
		end
		mag_s2  <= mag_s1;
		sh_s2   <= red_shift(mag_s1[0] | mag_s1[1] | mag_s1[2]);
		m_s4    <= m_s3;
		m_s5    <= m_s4;
		sum_s5  <= 64'(sq_s4[0]) + 64'(sq_s4[1]) + 64'(sq_s4[2]);
		neg_s2  <= neg_s1;
		neg_s3  <= neg_s2;
		neg_s4  <= neg_s3;
		neg_s5  <= neg_s4;
		side_s1 <= side_in;
		side_s2 <= side_s1;
		side_s3 <= side_s2;
		side_s4 <= side_s3;
		side_s5 <= side_s4;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
		end else begin
			vld_s1 <= vld_in;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
		end
	end

	logic              sq_vld;
	logic [31:0]       len_r;
	logic [IS_W-1:0]   sq_side;
	logic [2:0][30:0]  m_r;
	logic [2:0]        neg_r;
	logic [SIDE_W-1:0] side_r;

	sdf_isqrt #(.SIDE_W(IS_W)) u_isqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.vld_in   (vld_s5),
		.rad_in   (sum_s5),
		.side_in  ({m_s5, neg_s5, side_s5}),
		.vld_out  (sq_vld),
		.root_out (len_r),
		.side_out (sq_side)
	);

	assign {m_r, neg_r, side_r} = sq_side;

	// Rounded quotient: (m * 2^30 + len/2) / len, one quotient bit per stage.
	logic [2:0][61:0]  dvd;
	logic [2:0][31:0]  rem_s6;
	logic [2:0][30:0]  low_s6;
	logic [31:0]       len_s6;
	logic [2:0]        neg_s6;
	logic [SIDE_W-1:0] side_s6;
	logic              vld_s6;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			dvd[i] = {1'b0, m_r[i], 30'd0} + {31'd0, len_r[31:1]};
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			rem_s6[i] <= {1'b0, dvd[i][61:31]};
			low_s6[i] <= dvd[i][30:0];
		end
		len_s6  <= len_r;
		neg_s6  <= neg_r;
		side_s6 <= side_r;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s6 <= 1'b0;
		end else begin
			vld_s6 <= sq_vld;
		end
	end

	logic [2:0][31:0]  drem  [DIV_STEPS];
	logic [2:0][30:0]  dq    [DIV_STEPS];
	logic [2:0][30:0]  dlow  [DIV_STEPS];
	logic [31:0]       dlen  [DIV_STEPS];
	logic [2:0]        dneg  [DIV_STEPS];
	logic [SIDE_W-1:0] dside [DIV_STEPS];
	logic              dvld  [DIV_STEPS];

	for (genvar j = 0; j < DIV_STEPS; j++) begin : g_div
		logic [2:0][31:0]  rem_i;
		logic [2:0][30:0]  q_i, low_i;
		logic [31:0]       len_i;
		logic [2:0]        neg_i;
		logic [SIDE_W-1:0] side_i;
		logic              vld_i;
		logic [2:0][32:0]  r2;

		if (j == 0) begin : g_first
			assign rem_i  = rem_s6;
			assign q_i    = '0;
			assign low_i  = low_s6;
			assign len_i  = len_s6;
			assign neg_i  = neg_s6;
			assign side_i = side_s6;
			assign vld_i  = vld_s6;
		end else begin : g_next
			assign rem_i  = drem[j-1];
			assign q_i    = dq[j-1];
			assign low_i  = dlow[j-1];
			assign len_i  = dlen[j-1];
			assign neg_i  = dneg[j-1];
			assign side_i = dside[j-1];
			assign vld_i  = dvld[j-1];
		end

		always_comb begin
			for (int i = 0; i < 3; i++) begin
				r2[i] = {rem_i[i], low_i[i][30-j]};
			end
		end

		always_ff @(posedge clk) begin
			for (int i = 0; i < 3; i++) begin
				if (r2[i] >= {1'b0, len_i}) begin
					drem[j][i] <= 32'(r2[i] - {1'b0, len_i});
					dq[j][i]   <= {q_i[i][29:0], 1'b1};
				end else begin
					drem[j][i] <= r2[i][31:0];
					dq[j][i]   <= {q_i[i][29:0], 1'b0};
				end
			end
			dlow[j]  <= low_i;
			dlen[j]  <= len_i;
			dneg[j]  <= neg_i;
			dside[j] <= side_i;
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				dvld[j] <= 1'b0;
			end else begin
				dvld[j] <= vld_i;
			end
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			vec_out[i] <= dneg[DIV_STEPS-1][i] ? (32'd0 - {1'b0, dq[DIV_STEPS-1][i]})
				: {1'b0, dq[DIV_STEPS-1][i]};
		end
		ok_out   <= (dlen[DIV_STEPS-1] != 32'd0);
		side_out <= dside[DIV_STEPS-1];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_out <= 1'b0;
		end else begin
			vld_out <= dvld[DIV_STEPS-1];
		end
	end

endmodule

FILE: design/sdf_cross.sv
module sdf_cross import sdf_pkg::*; #(
	parameter int SIDE_W = 1
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              vld_in,
	input  vec_t              a,
	input  vec_t              b,
	input  logic [SIDE_W-1:0] side_in,
	output logic              vld_out,
	output wvec_t             c,
	output logic [SIDE_W-1:0] side_out
);

	logic signed [63:0] prod_s1 [6];
	logic [SIDE_W-1:0]  side_s1;
	logic               vld_s1;

	always_ff @(posedge clk) begin
		prod_s1[0] <= $signed(a[1]) * $signed(b[2]);
		prod_s1[1] <= $signed(a[2]) * $signed(b[1]);
		prod_s1[2] <= $signed(a[2]) * $signed(b[0]);
		prod_s1[3] <= $signed(a[0]) * $signed(b[2]);
		prod_s1[4] <= $signed(a[0]) * $signed(b[1]);
		prod_s1[5] <= $signed(a[1]) * $signed(b[0]);
		side_s1    <= side_in;
		c[0]       <= prod_s1[0] - prod_s1[1];
		c[1]       <= prod_s1[2] - prod_s1[3];
		c[2]       <= prod_s1[4] - prod_s1[5];
		side_out   <= side_s1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1  <= 1'b0;
			vld_out <= 1'b0;
		end else begin
			vld_s1  <= vld_in;
			vld_out <= vld_s1;
		end
	end

endmodule

FILE: design/shell_director_frame_top.sv
// Orthonormal director frame of a shell node.
// Command channel: a node normal (Q16.16) and its last_node mark form one beat,
// taken at each rising edge with start high and busy low. busy stays low, so a
// new beat may be issued every cycle, one item per cycle sustained.
// Result channel: done is high for exactly one cycle per item with the unit
// normal, both unit tangents (Q2.30) and the flags on the result ports. The
// receiver cannot hold results off; every beat must be taken when shown.
// From accept to done an item passes three normalizers in series, each with a
// 32-stage square root and a 31-stage divider, one bit per stage.
// Configuration: a valid/ready channel writes the reference vector (index 0
// to 2 for x, y, z); cfg_ready is always high. Write it only while no item is
// in flight. Reset clears all valid bits and loads the reference (0, 1, 0).
`include "assert_macros.svh"

module shell_director_frame_top import sdf_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic signed [31:0] normal_x,
	input  logic signed [31:0] normal_y,
	input  logic signed [31:0] normal_z,
	input  logic               last_node,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [1:0]         cfg_index,
	input  logic [31:0]        cfg_data,
	output logic               done,
	output logic signed [31:0] tan1_x,
	output logic signed [31:0] tan1_y,
	output logic signed [31:0] tan1_z,
	output logic signed [31:0] tan2_x,
	output logic signed [31:0] tan2_y,
	output logic signed [31:0] tan2_z,
	output logic signed [31:0] unit_nx,
	output logic signed [31:0] unit_ny,
	output logic signed [31:0] unit_nz,
	output logic               used_fallback,
	output logic               degenerate,
	output logic               last_out
);

	localparam int CT_W = $bits(ctl_t);
	localparam int S1_W = VEC_W * 3 + CT_W;
	localparam int S2_W = VEC_W * 6 + CT_W;

	// The pipeline never stalls, so a beat can be taken in every cycle with start high.
	assign busy      = 1'b0;
	assign cfg_ready = 1'b1;

	// Reference vector registers.
	logic [31:0] ref_x_q, ref_y_q, ref_z_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ref_x_q <= REF_X_RST;
			ref_y_q <= REF_Y_RST;
			ref_z_q <= REF_Z_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_REF_X: ref_x_q <= cfg_data;
				REG_REF_Y: ref_y_q <= cfg_data;
				REG_REF_Z: ref_z_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Normalize the node normal and the reference side by side. The reference
	// travels with every item so that each beat sees the vector it was issued with.
	wvec_t n_vec, r_vec;
	logic  acc;

	assign acc      = start && !busy;
	assign n_vec[0] = {{32{normal_x[31]}}, normal_x};
	assign n_vec[1] = {{32{normal_y[31]}}, normal_y};
	assign n_vec[2] = {{32{normal_z[31]}}, normal_z};
	assign r_vec[0] = {{32{ref_x_q[31]}}, ref_x_q};
	assign r_vec[1] = {{32{ref_y_q[31]}}, ref_y_q};
	assign r_vec[2] = {{32{ref_z_q[31]}}, ref_z_q};

	logic vld_a, ok_n, ok_r, last_a;
	vec_t n3_a, r3_a;

	sdf_norm #(.SIDE_W(1)) u_norm_n (
		.clk      (clk),
		.arst_n   (arst_n),
		.vld_in   (acc),
		.vec_in   (n_vec),
		.side_in  (last_node),
		.vld_out  (vld_a),
		.vec_out  (n3_a),
		.ok_out   (ok_n),
		.side_out (last_a)
	);

	sdf_norm #(.SIDE_W(1)) u_norm_r (
		.clk      (clk),
		.arst_n   (arst_n),
		.vld_in   (acc),
		.vec_in   (r_vec),
		.side_in  (1'b0),
		.vld_out  (),
		.vec_out  (r3_a),
		.ok_out   (ok_r),
		.side_out ()
	);

	// Raw first tangent r3 x n3 in Q4.60.
	ctl_t ctl_a;
	always_comb begin
		ctl_a      = '0;
		ctl_a.last = last_a;
		ctl_a.ok   = ok_n && ok_r;
	end

	logic            vld_x1;
	wvec_t           raw_x1;
	logic [S1_W-1:0] side_x1;
	vec_t            n3_x1;
	ctl_t            ctl_x1;

	sdf_cross #(.SIDE_W(S1_W)) u_cross_ref (
		.clk      (clk),
		.arst_n   (arst_n),
		.vld_in   (vld_a),
		.a        (r3_a),
		.b        (n3_a),
		.side_in  ({n3_a, ctl_a}),
		.vld_out  (vld_x1),
		.c        (raw_x1),
		.side_out (side_x1)
	);

	assign {n3_x1, ctl_x1} = side_x1;

	// Parallel test: round each component to Q2.30 and square it.
	logic [2:0][63:0] th_mag;
	logic [2:0][63:0] th_rnd;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			th_mag[i] = raw_x1[i][63] ? (64'd0 - raw_x1[i]) : raw_x1[i];
			th_rnd[i] = th_mag[i] + 64'd536870912;
		end
	end

	wvec_t raw_s1, sq_s1;
	vec_t  n3_s1;
	ctl_t  ctl_s1;
	logic  vld_s1;

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			sq_s1[i] <= th_rnd[i][61:30] * th_rnd[i][61:30];
		end
		raw_s1 <= raw_x1;
		n3_s1  <= n3_x1;
		ctl_s1 <= ctl_x1;
	end

	// At or below the threshold the x axis is used: n3 x e1 = (0, n3z, -n3y).
	logic [63:0] th_sum;
	logic        fb_s1;
	logic [31:0] neg_ny;
	wvec_t       fbv_s1;
	ctl_t        ctl_fb;

	always_comb begin
		th_sum    = sq_s1[0] + sq_s1[1] + sq_s1[2];
		fb_s1     = ctl_s1.ok && (th_sum <= FB_THRESH_SQ);
		neg_ny    = 32'd0 - n3_s1[1];
		fbv_s1[0] = '0;
		fbv_s1[1] = {{32{n3_s1[2][31]}}, n3_s1[2]};
		fbv_s1[2] = {{32{neg_ny[31]}}, neg_ny};
		ctl_fb    = ctl_s1;
		ctl_fb.fb = fb_s1;
	end

	wvec_t x_s2;
	vec_t  n3_s2;
	ctl_t  ctl_s2;
	logic  vld_s2;

	always_ff @(posedge clk) begin
		x_s2   <= fb_s1 ? fbv_s1 : raw_s1;
		n3_s2  <= n3_s1;
		ctl_s2 <= ctl_fb;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else begin
			vld_s1 <= vld_x1;
			vld_s2 <= vld_s1;
		end
	end

	// First normalizer: t1 on the normal path, t2 on the fallback path.
	logic            vld_b, ok_b;
	vec_t            u_b, n3_b;
	logic [S1_W-1:0] side_b;
	ctl_t            ctl_b, ctl_bb;

	sdf_norm #(.SIDE_W(S1_W)) u_norm_first (
		.clk      (clk),
		.arst_n   (arst_n),
		.vld_in   (vld_s2),
		.vec_in   (x_s2),
		.side_in  ({n3_s2, ctl_s2}),
		.vld_out  (vld_b),
		.vec_out  (u_b),
		.ok_out   (ok_b),
		.side_out (side_b)
	);

	assign {n3_b, ctl_b} = side_b;

	vec_t ca_b, cb_b, fbn_b;

	always_comb begin
		ctl_bb     = ctl_b;
		ctl_bb.ok1 = ok_b;
		fbn_b[0]   = '0;
		fbn_b[1]   = n3_b[2];
		fbn_b[2]   = 32'd0 - n3_b[1];
		// Normal path n3 x t1; fallback path (n3 x e1) x n3, unnormalized.
		ca_b       = ctl_b.fb ? fbn_b : n3_b;
		cb_b       = ctl_b.fb ? n3_b : u_b;
	end

	logic            vld_x2;
	wvec_t           y_x2;
	logic [S2_W-1:0] side_x2;

	sdf_cross #(.SIDE_W(S2_W)) u_cross_frame (
		.clk      (clk),
		.arst_n   (arst_n),
		.vld_in   (vld_b),
		.a        (ca_b),
		.b        (cb_b),
		.side_in  ({n3_b, u_b, ctl_bb}),
		.vld_out  (vld_x2),
		.c        (y_x2),
		.side_out (side_x2)
	);

	// Second normalizer: the remaining tangent.
	logic            vld_c, ok_c;
	vec_t            w_c, n3_c, u_c;
	logic [S2_W-1:0] side_c;
	ctl_t            ctl_c;

	sdf_norm #(.SIDE_W(S2_W)) u_norm_second (
		.clk      (clk),
		.arst_n   (arst_n),
		.vld_in   (vld_x2),
		.vec_in   (y_x2),
		.side_in  (side_x2),
		.vld_out  (vld_c),
		.vec_out  (w_c),
		.ok_out   (ok_c),
		.side_out (side_c)
	);

	assign {n3_c, u_c, ctl_c} = side_c;

	// Result register: any zero length met on the way clears all vectors.
	logic ok_all;
	vec_t t1_q, t2_q, un_q;
	logic fb_q, dg_q, last_q, done_q;

	assign ok_all = ctl_c.ok && ctl_c.ok1 && ok_c;

	always_ff @(posedge clk) begin
		t1_q   <= !ok_all ? '0 : (ctl_c.fb ? w_c : u_c);
		t2_q   <= !ok_all ? '0 : (ctl_c.fb ? u_c : w_c);
		un_q   <= !ok_all ? '0 : n3_c;
		fb_q   <= ctl_c.fb;
		dg_q   <= !ok_all;
		last_q <= ctl_c.last;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= vld_c;
		end
	end

	assign done          = done_q;
	assign tan1_x        = t1_q[0];
	assign tan1_y        = t1_q[1];
	assign tan1_z        = t1_q[2];
	assign tan2_x        = t2_q[0];
	assign tan2_y        = t2_q[1];
	assign tan2_z        = t2_q[2];
	assign unit_nx       = un_q[0];
	assign unit_ny       = un_q[1];
	assign unit_nz       = un_q[2];
	assign used_fallback = fb_q;
	assign degenerate    = dg_q;
	assign last_out      = last_q;

	// Every result beat matches an item accepted at the head of the full frame pipeline.
	`SDF_ASSERT_IMP(a_latency, clk, arst_n, done, $past(start && !busy, FRAME_LAT), "result beat without a matching accepted item")
	// A degenerate frame carries only zero vectors.
	`SDF_ASSERT_IMP(a_degen_zero, clk, arst_n, done && degenerate, tan1_x == 0 && tan1_y == 0 && tan1_z == 0 && tan2_x == 0 && tan2_y == 0 && tan2_z == 0 && unit_nx == 0 && unit_ny == 0 && unit_nz == 0, "degenerate frame with nonzero vector")
	// A valid frame has a nonzero unit normal and first tangent.
	`SDF_ASSERT_IMP(a_frame_nonzero, clk, arst_n, done && !degenerate, (unit_nx != 0 || unit_ny != 0 || unit_nz != 0) && (tan1_x != 0 || tan1_y != 0 || tan1_z != 0), "valid frame with zero vector")

endmodule

FILE: dv/shell_director_frame_top_tb.sv
// Self-checking bench for the shell director frame block.
// Each beat of node normals is predicted with a bit-accurate fixed-point model,
// held in a queue until the matching frame comes out on done, and compared
// field by field there.
module shell_director_frame_top_tb;
	import sdf_pkg::*;

	typedef longint trip_t [3];

	// One predicted frame.
	typedef struct {
		logic [31:0] t1 [3];
		logic [31:0] t2 [3];
		logic [31:0] un [3];
		logic        fb;
		logic        degen;
		logic        last;
	} frame_t;

	typedef struct {
		logic [31:0] nx, ny, nz;
		logic        last;
	} node_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic signed [31:0] normal_x = '0, normal_y = '0, normal_z = '0;
	logic last_node = 1'b0;
	logic cfg_valid = 1'b0;
	logic [1:0] cfg_index = REG_REF_X;
	logic [31:0] cfg_data = '0;
	logic busy, cfg_ready, done;
	logic signed [31:0] tan1_x, tan1_y, tan1_z, tan2_x, tan2_y, tan2_z;
	logic signed [31:0] unit_nx, unit_ny, unit_nz;
	logic used_fallback, degenerate, last_out;

	// The reference vector as the bench believes the block holds it.
	logic [31:0] ref_vec [3];

	node_t  pending_nodes [$];
	frame_t frames_due [$];
	int     fail_count = 0;
	bit     hold_sender = 1'b0;
	bit     steady = 1'b0;

	shell_director_frame_top dut (.*);

	always #5 clk = ~clk;

	initial begin
		#2_000_000;
		$display("shell_director_frame_top: mismatch");
		$finish;
	end

	// Integer square root, floor, one result bit per pass.
	function automatic logic [63:0] root_floor(logic [63:0] v);
		logic [63:0] res, probe;
		res = 0;
		probe = 64'd1 << 62;
		while (probe > v)
			probe >>= 2;
		while (probe != 0) begin
			if (v >= res + probe) begin
				v -= res + probe;
				res = (res >> 1) + probe;
			end else begin
				res >>= 1;
			end
			probe >>= 2;
		end
		return res;
	endfunction

	function automatic logic [63:0] magn(longint v);
		return v < 0 ? 64'd0 - 64'(v) : 64'(v);
	endfunction

	// Scale a wide vector to unit length in Q2.30; returns 0 on zero length.
	function automatic bit to_unit(input trip_t v, output trip_t o);
		logic [63:0] m [3];
		logic [63:0] sum, len, q;
		int s;
		s = 0;
		sum = 0;
		for (int i = 0; i < 3; i++)
			m[i] = magn(v[i]);
		while (((m[0] >> s) | (m[1] >> s) | (m[2] >> s)) >= (64'd1 << 31))
			s++;
		for (int i = 0; i < 3; i++) begin
			m[i] >>= s;
			sum += m[i] * m[i];
		end
		len = root_floor(sum);
		o = '{0, 0, 0};
		if (len == 0)
			return 1'b0;
		for (int i = 0; i < 3; i++) begin
			q = ((m[i] << 30) + len / 2) / len;
			o[i] = v[i] < 0 ? -longint'(q) : longint'(q);
		end
		return 1'b1;
	endfunction

	function automatic trip_t cross3(trip_t a, trip_t b);
		trip_t c;
		c[0] = a[1] * b[2] - a[2] * b[1];
		c[1] = a[2] * b[0] - a[0] * b[2];
		c[2] = a[0] * b[1] - a[1] * b[0];
		return c;
	endfunction

	// Build the expected frame of one node against the current reference.
	function automatic frame_t director_frame(node_t nd);
		trip_t n, r, n3, r3, raw1, t1, t2, tmp;
		logic [63:0] sum, q;
		bit ok, fb;
		frame_t f;
		n = '{longint'($signed(nd.nx)), longint'($signed(nd.ny)),
			longint'($signed(nd.nz))};
		for (int i = 0; i < 3; i++)
			r[i] = longint'($signed(ref_vec[i]));
		t1 = '{0, 0, 0};
		t2 = '{0, 0, 0};
		fb = 1'b0;
		ok = to_unit(n, n3);
		ok = to_unit(r, r3) && ok;
		if (ok) begin
			raw1 = cross3(r3, n3);
			sum = 0;
			for (int i = 0; i < 3; i++) begin
				q = (magn(raw1[i]) + (64'd1 << 29)) >> 30;
				sum += q * q;
			end
			if (sum > FB_THRESH_SQ) begin
				ok = to_unit(raw1, t1);
				tmp = cross3(n3, t1);
				ok = to_unit(tmp, t2) && ok;
			end else begin
				// Normal runs along the reference: fall back to the x axis.
				fb = 1'b1;
				tmp = '{0, n3[2], -n3[1]};
				ok = to_unit(tmp, t2);
				raw1 = cross3(tmp, n3);
				ok = to_unit(raw1, t1) && ok;
			end
		end
		for (int i = 0; i < 3; i++) begin
			f.t1[i] = ok ? t1[i][31:0] : '0;
			f.t2[i] = ok ? t2[i][31:0] : '0;
			f.un[i] = ok ? n3[i][31:0] : '0;
		end
		f.fb = fb;
		f.degen = !ok;
		f.last = nd.last;
		return f;
	endfunction

	// Driver: the beat on the ports is taken at an edge with start high and
	// busy low; its frame is predicted right then, with the reference in force.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start <= 1'b0;
		end else begin
			if (start && !busy)
				frames_due.push_back(director_frame('{normal_x, normal_y, normal_z,
					last_node}));
			if (!start || !busy) begin
				if (pending_nodes.size() > 0 && !hold_sender &&
						(steady || $urandom_range(99) >= 22)) begin
					node_t nd;
					nd = pending_nodes.pop_front();
					normal_x <= nd.nx;
					normal_y <= nd.ny;
					normal_z <= nd.nz;
					last_node <= nd.last;
					start <= 1'b1;
				end else begin
					start <= 1'b0;
				end
			end
		end
	end

	task automatic report(string what, logic [31:0] got, logic [31:0] want);
		$display("frame check: %s got %h want %h", what, got, want);
		fail_count++;
	endtask

	// Monitor: done lasts one cycle, so every strobe is taken at once.
	always @(posedge clk) begin
		if (arst_n && done) begin
			if (frames_due.size() == 0) begin
				report("unexpected frame", 0, 0);
			end else begin
				frame_t f;
				f = frames_due.pop_front();
				if (tan1_x !== f.t1[0]) report("tan1_x", tan1_x, f.t1[0]);
				if (tan1_y !== f.t1[1]) report("tan1_y", tan1_y, f.t1[1]);
				if (tan1_z !== f.t1[2]) report("tan1_z", tan1_z, f.t1[2]);
				if (tan2_x !== f.t2[0]) report("tan2_x", tan2_x, f.t2[0]);
				if (tan2_y !== f.t2[1]) report("tan2_y", tan2_y, f.t2[1]);
				if (tan2_z !== f.t2[2]) report("tan2_z", tan2_z, f.t2[2]);
				if (unit_nx !== f.un[0]) report("unit_nx", unit_nx, f.un[0]);
				if (unit_ny !== f.un[1]) report("unit_ny", unit_ny, f.un[1]);
				if (unit_nz !== f.un[2]) report("unit_nz", unit_nz, f.un[2]);
				if (used_fallback !== f.fb) report("used_fallback", used_fallback, f.fb);
				if (degenerate !== f.degen) report("degenerate", degenerate, f.degen);
				if (last_out !== f.last) report("last_out", last_out, f.last);
			end
		end
	end

	// Block until nothing is queued, on the ports, or still in the pipeline.
	task automatic drain();
		do
			@(posedge clk);
		while (pending_nodes.size() > 0 || start || frames_due.size() > 0);
	endtask

	task automatic write_ref(cfg_reg_t idx, logic [31:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do
			@(posedge clk);
		while (!cfg_ready);
		ref_vec[idx] = val;
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic set_ref(logic [31:0] x, logic [31:0] y, logic [31:0] z);
		drain();
		write_ref(REG_REF_X, x);
		write_ref(REG_REF_Y, y);
		write_ref(REG_REF_Z, z);
	endtask

	function automatic logic [31:0] rnd_word();
		case ($urandom_range(3))
			0: return $urandom;
			1: return $signed($urandom_range(20000)) - 10000;
			2: return $urandom_range(1) ? 32'h7fffffff : 32'h80000000;
			default: return $signed($urandom) >>> $urandom_range(31);
		endcase
	endfunction

	// A random node; many lie along the reference (scaled copies, with or
	// without a tiny offset) so the fallback path is reached often.
	function automatic node_t rnd_node();
		node_t nd;
		int sh;
		nd.last = $urandom_range(1);
		case ($urandom_range(9))
			0, 1, 2, 3: begin
				nd.nx = rnd_word();
				nd.ny = rnd_word();
				nd.nz = rnd_word();
			end
			4, 5, 6: begin
				sh = $urandom_range(8);
				nd.nx = $signed(ref_vec[0]) >>> sh;
				nd.ny = $signed(ref_vec[1]) >>> sh;
				nd.nz = $signed(ref_vec[2]) >>> sh;
				if ($urandom_range(1)) begin
					nd.nx = -nd.nx;
					nd.ny = -nd.ny;
					nd.nz = -nd.nz;
				end
				if ($urandom_range(2) == 0)
					nd.nz += $signed($urandom_range(6)) - 3;
			end
			7: begin
				// Along an axis, possibly the x axis itself.
				nd.nx = $urandom_range(1) ? rnd_word() : 0;
				nd.ny = 0;
				nd.nz = 0;
				if ($urandom_range(1)) begin
					nd.ny = nd.nx;
					nd.nx = 0;
				end
			end
			default: begin
				nd.nx = $signed($urandom_range(6)) - 3;
				nd.ny = $signed($urandom_range(6)) - 3;
				nd.nz = $signed($urandom_range(6)) - 3;
			end
		endcase
		return nd;
	endfunction

	initial begin
		ref_vec = '{REF_X_RST, REF_Y_RST, REF_Z_RST};
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed nodes under the reset reference (0, 1, 0): a zero normal,
		// field extremes, normals along the reference (fallback), a tiny
		// normal, and a normal on the x axis.
		pending_nodes.push_back('{32'd0, 32'd0, 32'd0, 1'b0});
		pending_nodes.push_back('{32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 1'b1});
		pending_nodes.push_back('{32'h80000000, 32'h80000000, 32'h80000000, 1'b0});
		pending_nodes.push_back('{32'h80000000, 32'h7fffffff, 32'd0, 1'b1});
		pending_nodes.push_back('{32'd0, 32'd65536, 32'd0, 1'b0});
		pending_nodes.push_back('{32'd0, -32'sd3, 32'd0, 1'b1});
		pending_nodes.push_back('{32'd0, 32'h80000000, 32'd0, 1'b0});
		pending_nodes.push_back('{32'd1, 32'd0, 32'd0, 1'b0});
		pending_nodes.push_back('{32'd0, 32'd0, 32'h80000000, 1'b1});
		pending_nodes.push_back('{32'd65536, 32'd0, 32'd0, 1'b1});
		pending_nodes.push_back('{32'd1, 32'h7fffffff, 32'd0, 1'b0});

		// Reference on the x axis: a normal on x is the double degenerate case.
		set_ref(32'd65536, 32'd0, 32'd0);
		pending_nodes.push_back('{32'd65536, 32'd0, 32'd0, 1'b0});
		pending_nodes.push_back('{-32'sd7, 32'd0, 32'd0, 1'b1});
		pending_nodes.push_back('{32'd0, 32'd0, 32'd65536, 1'b0});

		// A zero reference makes every frame degenerate.
		set_ref(32'd0, 32'd0, 32'd0);
		pending_nodes.push_back('{32'd0, 32'd0, 32'd65536, 1'b1});
		pending_nodes.push_back('{32'd0, 32'd0, 32'd0, 1'b0});

		// Extreme reference components.
		set_ref(32'h7fffffff, 32'h80000000, 32'h7fffffff);
		pending_nodes.push_back('{32'h7fffffff, 32'h80000000, 32'h7fffffff, 1'b0});
		pending_nodes.push_back('{32'h80000000, 32'h7fffffff, 32'h80000000, 1'b1});
		pending_nodes.push_back('{32'd3, 32'd5, -32'sd9, 1'b0});

		// The sender holds off until the pipeline has emptied.
		hold_sender = 1'b1;
		do
			@(posedge clk);
		while (start || frames_due.size() > 0);
		hold_sender = 1'b0;

		// Random phases, each under a fresh reference; one phase runs with no
		// idle cycles at all.
		for (int ph = 0; ph < 7; ph++) begin
			case (ph)
				0: set_ref(REF_X_RST, REF_Y_RST, REF_Z_RST);
				1: set_ref(32'h80000000, 32'h80000000, 32'h80000000);
				2: set_ref(32'd1, 32'd0, 32'd0);
				default: set_ref(rnd_word(), rnd_word(), rnd_word());
			endcase
			steady = (ph == 3);
			for (int k = 0; k < 150; k++)
				pending_nodes.push_back(rnd_node());
		end

		drain();
		steady = 1'b0;
		repeat (FRAME_LAT + 20) @(posedge clk);
		if (fail_count == 0)
			$display("shell_director_frame_top: match");
		else
			$display("shell_director_frame_top: mismatch");
		$finish;
	end
endmodule
